### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Implication into the next cycle, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### rtl/pffc_pkg.sv
`timescale 1ns / 1ps

package pffc_pkg;

	localparam int PIX_W       = 64;
	localparam int DIM_REG_W   = 15;
	localparam int PB_W        = 4;
	localparam int LB_W        = 18;
	localparam int OFF_W       = 31;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 18;
	localparam int MAX_DIM_DEF = 16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_DST_WIDTH  = 3'd2,
		REG_DST_HEIGHT = 3'd3,
		REG_SRC_PB     = 3'd4,
		REG_DST_PB     = 3'd5,
		REG_SRC_LB     = 3'd6,
		REG_DST_LB     = 3'd7
	} reg_idx_t;

	// Byte select code: 0 to 7 pick an input byte, SEL_Z and SEL_F force zero and all ones.
	typedef logic [3:0] byte_sel_t;
	localparam byte_sel_t SEL_Z = 4'd8;
	localparam byte_sel_t SEL_F = 4'd9;

	typedef struct packed {
		logic       ok;
		logic [1:0] idx;
	} size_sel_t;

	// Indexed by destination size, then source size, in the order 3, 4, 6, 8 bytes.
	localparam byte_sel_t CONV_MAP [4][4][8] = '{
		'{
			'{4'd0, 4'd1, 4'd2, SEL_Z, SEL_Z, SEL_Z, SEL_Z, SEL_Z},
			'{4'd1, 4'd2, 4'd3, SEL_Z, SEL_Z, SEL_Z, SEL_Z, SEL_Z},
			'{4'd0, 4'd2, 4'd4, SEL_Z, SEL_Z, SEL_Z, SEL_Z, SEL_Z},
			'{4'd2, 4'd4, 4'd6, SEL_Z, SEL_Z, SEL_Z, SEL_Z, SEL_Z}
		},
		'{
			'{SEL_F, 4'd0, 4'd1, 4'd2, SEL_Z, SEL_Z, SEL_Z, SEL_Z},
			'{4'd0, 4'd1, 4'd2, 4'd3, SEL_Z, SEL_Z, SEL_Z, SEL_Z},
			'{SEL_F, 4'd0, 4'd2, 4'd4, SEL_Z, SEL_Z, SEL_Z, SEL_Z},
			'{4'd0, 4'd2, 4'd4, 4'd6, SEL_Z, SEL_Z, SEL_Z, SEL_Z}
		},
		'{
			'{4'd0, SEL_Z, 4'd1, SEL_Z, 4'd2, SEL_Z, SEL_Z, SEL_Z},
			'{4'd1, SEL_Z, 4'd2, SEL_Z, 4'd3, SEL_Z, SEL_Z, SEL_Z},
			'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, SEL_Z, SEL_Z},
			'{4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, SEL_Z, SEL_Z}
		},
		'{
			'{SEL_F, SEL_F, 4'd0, SEL_Z, 4'd1, SEL_Z, 4'd2, SEL_Z},
			'{4'd0, SEL_Z, 4'd1, SEL_Z, 4'd2, SEL_Z, 4'd3, SEL_Z},
			'{SEL_F, SEL_F, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5},
			'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7}
		}
	};

	function automatic size_sel_t size_index(input logic [PB_W-1:0] b);
		size_sel_t r;
		case (b)
			4'd3: r = '{ok: 1'b1, idx: 2'd0};
			4'd4: r = '{ok: 1'b1, idx: 2'd1};
			4'd6: r = '{ok: 1'b1, idx: 2'd2};
			4'd8: r = '{ok: 1'b1, idx: 2'd3};
			default: r = '{ok: 1'b0, idx: 2'd0};
		endcase
		return r;
	endfunction

endpackage

### rtl/pffc_convert.sv
`timescale 1ns / 1ps

module pffc_convert import pffc_pkg::*; (
	input  logic [PIX_W-1:0] src_pixel,
	input  logic [PB_W-1:0]  src_pixel_bytes,
	input  logic [PB_W-1:0]  dst_pixel_bytes,
	output logic [PIX_W-1:0] dst_pixel
);

	size_sel_t si;
	size_sel_t di;
	byte_sel_t sel;

	always_comb begin
		si = size_index(src_pixel_bytes);
		di = size_index(dst_pixel_bytes);
		dst_pixel = '0;
		sel = SEL_Z;
		for (int k = 0; k < 8; k++) begin
			sel = CONV_MAP[di.idx][si.idx][k];
			case (sel)
				SEL_Z: dst_pixel[8*k +: 8] = 8'h00;
				SEL_F: dst_pixel[8*k +: 8] = 8'hFF;
				default: dst_pixel[8*k +: 8] = src_pixel[8*sel[2:0] +: 8];
			endcase
		end
		if (!si.ok || !di.ok) begin
			dst_pixel = '0;
		end
	end

endmodule

### rtl/pixel_frame_format_convert.sv
`timescale 1ns / 1ps

// Converts one destination pixel per clock between 3, 4, 6 and 8 byte layouts while
// walking the destination raster in row order, centering it on the source image and
// giving zero pixels outside the source; each result also carries the source and
// destination byte offsets and an end-of-frame mark. A beat goes through four
// register stages (position, conversion, offset products, offset sums), and a new beat
// is taken every cycle for as long as results are taken; the offset multipliers set
// the depth. The user must write the registers through the configuration port only
// while no beat is in flight; the block itself does not enforce this.
module pixel_frame_format_convert import pffc_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      src_pixel,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      dst_pixel,
	output logic                  inside_res,
	output logic [OFF_W-1:0]      src_offset,
	output logic [OFF_W-1:0]      dst_offset,
	output logic                  end_of_frame
);

	localparam int CW   = $clog2(MAX_DIM);
	localparam int DIMW = CW + 1;

	logic [DIM_REG_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic [PB_W-1:0]      src_pb_q, dst_pb_q;
	logic [LB_W-1:0]      src_lb_q, dst_lb_q;
	logic [CW-1:0]        col_q, row_q;

	logic [DIMW-1:0]      sw, sh, dw, dh;
	logic signed [DIMW:0] half_x, half_y, sx, sy;
	logic                 last_col, last_row, in_sx, in_sy;
	logic                 en1, en2, en3, en4;

	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic [PIX_W-1:0]     pix_s1, pix_s2, pix_s3, pix_s4;
	logic [CW-1:0]        x_s1, y_s1, x_s2, y_s2, sx_s2, sy_s2;
	logic                 eof_s1, eof_s2, eof_s3, eof_s4;
	logic                 inside_s2, inside_s3, inside_s4;
	logic [OFF_W-1:0]     sprod_y_s3, sprod_x_s3, dprod_y_s3, dprod_x_s3;
	logic [OFF_W-1:0]     soff_s4, doff_s4;
	logic [PIX_W-1:0]     conv_pix;

	function automatic logic [DIMW-1:0] eff_dim(input logic [DIM_REG_W-1:0] v);
		logic [DIMW-1:0] r;
		if (v == '0) begin
			r = DIMW'(1);
		end else if (int'(v) > MAX_DIM) begin
			r = DIMW'(MAX_DIM);
		end else begin
			r = DIMW'(v);
		end
		return r;
	endfunction

	function automatic logic signed [DIMW:0] half_diff(input logic [DIMW-1:0] s,
			input logic [DIMW-1:0] d);
		logic signed [DIMW:0] diff;
		diff = $signed({1'b0, s}) - $signed({1'b0, d});
		// Round toward zero: bias negative values by one before the shift.
		return (diff + $signed({{DIMW{1'b0}}, diff[DIMW]})) >>> 1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= DIM_REG_W'(1);
			src_height_q <= DIM_REG_W'(1);
			dst_width_q  <= DIM_REG_W'(1);
			dst_height_q <= DIM_REG_W'(1);
			src_pb_q     <= PB_W'(3);
			dst_pb_q     <= PB_W'(3);
			src_lb_q     <= LB_W'(3);
			dst_lb_q     <= LB_W'(3);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[DIM_REG_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[DIM_REG_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= cfg_data[DIM_REG_W-1:0];
				REG_DST_HEIGHT: dst_height_q <= cfg_data[DIM_REG_W-1:0];
				REG_SRC_PB:     src_pb_q     <= cfg_data[PB_W-1:0];
				REG_DST_PB:     dst_pb_q     <= cfg_data[PB_W-1:0];
				REG_SRC_LB:     src_lb_q     <= cfg_data[LB_W-1:0];
				REG_DST_LB:     dst_lb_q     <= cfg_data[LB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sw = eff_dim(src_width_q);
		sh = eff_dim(src_height_q);
		dw = eff_dim(dst_width_q);
		dh = eff_dim(dst_height_q);
		half_x = half_diff(sw, dw);
		half_y = half_diff(sh, dh);
		last_col = (DIMW'(col_q) + DIMW'(1)) >= dw;
		last_row = (DIMW'(row_q) + DIMW'(1)) >= dh;
		sx = $signed({2'b00, x_s1}) + half_x;
		sy = $signed({2'b00, y_s1}) + half_y;
		in_sx = !sx[DIMW] && (sx[DIMW-1:0] < sw);
		in_sy = !sy[DIMW] && (sy[DIMW-1:0] < sh);
	end

	assign en4 = !valid_s4 || !out_stall;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (in_valid && en1) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + CW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (en1) begin
				valid_s1 <= in_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (en4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	pffc_convert u_convert (
		.src_pixel       (pix_s1),
		.src_pixel_bytes (src_pb_q),
		.dst_pixel_bytes (dst_pb_q),
		.dst_pixel       (conv_pix)
	);

	always_ff @(posedge clk) begin
		if (en1) begin
			pix_s1 <= src_pixel;
			x_s1   <= col_q;
			y_s1   <= row_q;
			eof_s1 <= last_col && last_row;
		end
		if (en2) begin
			inside_s2 <= in_sx && in_sy;
			pix_s2    <= (in_sx && in_sy) ? conv_pix : '0;
			sx_s2     <= (in_sx && in_sy) ? sx[CW-1:0] : '0;
			sy_s2     <= (in_sx && in_sy) ? sy[CW-1:0] : '0;
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			eof_s2    <= eof_s1;
		end
		if (en3) begin
			sprod_y_s3 <= OFF_W'(sy_s2) * OFF_W'(src_lb_q);
			sprod_x_s3 <= OFF_W'(sx_s2) * OFF_W'(src_pb_q);
			dprod_y_s3 <= OFF_W'(y_s2) * OFF_W'(dst_lb_q);
			dprod_x_s3 <= OFF_W'(x_s2) * OFF_W'(dst_pb_q);
			pix_s3     <= pix_s2;
			inside_s3  <= inside_s2;
			eof_s3     <= eof_s2;
		end
		if (en4) begin
			soff_s4   <= sprod_y_s3 + sprod_x_s3;
			doff_s4   <= dprod_y_s3 + dprod_x_s3;
			pix_s4    <= pix_s3;
			inside_s4 <= inside_s3;
			eof_s4    <= eof_s3;
		end
	end

	assign out_valid    = valid_s4;
	assign dst_pixel    = pix_s4;
	assign inside_res   = inside_s4;
	assign src_offset   = soff_s4;
	assign dst_offset   = doff_s4;
	assign end_of_frame = eof_s4;

endmodule

### rtl/pffc_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pffc_checker import pffc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [PIX_W-1:0] dst_pixel,
	input logic             inside_res,
	input logic [OFF_W-1:0] src_offset
);

	logic [2:0] pending_q;
	logic       in_beat, out_beat;

	assign in_beat  = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_beat && !out_beat) begin
			pending_q <= pending_q + 3'd1;
		end else if (out_beat && !in_beat) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(dst_pixel) && $stable(src_offset), "stalled result beat changed")
	`ASSERT_IMPL(a_outside_zero, clk, arst_n, out_valid && !inside_res, dst_pixel == '0 && src_offset == '0, "outside pixel is not zero")
	`ASSERT_IMPL(a_pending_max, clk, arst_n, 1'b1, pending_q <= 3'd4, "more beats in flight than pipeline stages")
	`ASSERT_IMPL(a_no_phantom, clk, arst_n, out_valid, pending_q != 3'd0, "result beat without an input beat")

endmodule

bind pixel_frame_format_convert pffc_checker u_pffc_checker (.*);

### bench/tb_pixel_frame_format_convert.sv
`timescale 1ns / 1ps

module tb_pixel_frame_format_convert;
	import pffc_pkg::*;

	localparam int ITEM_TARGET    = 1150;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_AT_BEAT   = 300;
	localparam int HOLD_CYCLES    = 250;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             in_src;
		logic [OFF_W-1:0] src_off;
		logic [OFF_W-1:0] dst_off;
		logic             eof;
	} pix_result_t;

	typedef struct packed {
		logic                  is_write;
		reg_idx_t              idx;
		logic [CFG_DATA_W-1:0] data;
		logic [PIX_W-1:0]      pixel;
		logic                  typed;
		pix_result_t           want;
	} script_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [PIX_W-1:0]      src_pixel;
	logic                  out_valid;
	logic                  out_stall;
	logic [PIX_W-1:0]      dst_pixel;
	logic                  inside_res;
	logic [OFF_W-1:0]      src_offset;
	logic [OFF_W-1:0]      dst_offset;
	logic                  end_of_frame;

	pixel_frame_format_convert dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.src_pixel(src_pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dst_pixel(dst_pixel),
		.inside_res(inside_res),
		.src_offset(src_offset),
		.dst_offset(dst_offset),
		.end_of_frame(end_of_frame)
	);

	// Shadow copy of the frame registers and the raster position.
	logic [DIM_REG_W-1:0] frame_src_w, frame_src_h, frame_dst_w, frame_dst_h;
	logic [PB_W-1:0]      src_bpp, dst_bpp;
	logic [LB_W-1:0]      src_stride, dst_stride;
	int                   walk_x, walk_y;

	pix_result_t expected_pixels[$];
	script_row_t script[$];
	pix_result_t seen, want;
	int          beats_sent;
	int          quiet_cycles;
	bit          failed;
	bit          tx_burst, rx_burst;
	bit          hold_done;
	bit          hold_go;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int idle_len(input bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int clamp_dim(input logic [DIM_REG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM_DEF)
			return MAX_DIM_DEF;
		return int'(v);
	endfunction

	function automatic bit bpp_ok(input logic [PB_W-1:0] b);
		return b == 4'd3 || b == 4'd4 || b == 4'd6 || b == 4'd8;
	endfunction

	// Samples are alpha then three colors, each kept as a first and second byte.
	function automatic logic [PIX_W-1:0] repack_pixel(input logic [PIX_W-1:0] pix,
			input logic [PB_W-1:0] from_b, input logic [PB_W-1:0] to_b);
		logic [7:0]       first [4];
		logic [7:0]       second [4];
		logic             src_alpha, src_wide, dst_alpha, dst_wide;
		int               k, p;
		logic [PIX_W-1:0] res;
		if (!bpp_ok(from_b) || !bpp_ok(to_b))
			return '0;
		src_alpha = from_b == 4'd4 || from_b == 4'd8;
		src_wide  = from_b >= 4'd6;
		dst_alpha = to_b == 4'd4 || to_b == 4'd8;
		dst_wide  = to_b >= 4'd6;
		for (int j = 0; j < 4; j++) begin
			if (j == 0 && !src_alpha) begin
				first[j]  = 8'hFF;
				second[j] = 8'hFF;
			end else begin
				k = src_alpha ? j : j - 1;
				if (src_wide) begin
					first[j]  = pix[16*k +: 8];
					second[j] = pix[16*k+8 +: 8];
				end else begin
					first[j]  = pix[8*k +: 8];
					second[j] = 8'h00;
				end
			end
		end
		res = '0;
		p = 0;
		for (int j = 0; j < 4; j++) begin
			if (j != 0 || dst_alpha) begin
				if (dst_wide) begin
					res[16*p +: 8]   = first[j];
					res[16*p+8 +: 8] = second[j];
				end else begin
					res[8*p +: 8] = first[j];
				end
				p++;
			end
		end
		return res;
	endfunction

	function automatic pix_result_t predict_pixel(input logic [PIX_W-1:0] pix);
		pix_result_t     r;
		int              sw, sh, dw, dh, x, y, sx, sy;
		bit              in_src, last_col, last_row;
		longint unsigned soff, doff;
		sw = clamp_dim(frame_src_w);
		sh = clamp_dim(frame_src_h);
		dw = clamp_dim(frame_dst_w);
		dh = clamp_dim(frame_dst_h);
		x  = walk_x;
		y  = walk_y;
		sx = x + (sw - dw) / 2;
		sy = y + (sh - dh) / 2;
		in_src   = sx >= 0 && sx < sw && sy >= 0 && sy < sh;
		last_col = x >= dw - 1;
		last_row = y >= dh - 1;
		soff = 0;
		if (in_src)
			soff = longint'(sy) * src_stride + longint'(sx) * src_bpp;
		doff = longint'(y) * dst_stride + longint'(x) * dst_bpp;
		r.pixel   = in_src ? repack_pixel(pix, src_bpp, dst_bpp) : '0;
		r.in_src  = in_src;
		r.src_off = soff[OFF_W-1:0];
		r.dst_off = doff[OFF_W-1:0];
		r.eof     = last_col && last_row;
		if (last_col) begin
			walk_x = 0;
			walk_y = last_row ? 0 : walk_y + 1;
		end else begin
			walk_x++;
		end
		return r;
	endfunction

	function automatic script_row_t cfg_row(input reg_idx_t idx,
			input logic [CFG_DATA_W-1:0] data);
		script_row_t r;
		r = '0;
		r.is_write = 1'b1;
		r.idx      = idx;
		r.data     = data;
		return r;
	endfunction

	function automatic script_row_t beat_row(input logic [PIX_W-1:0] pix);
		script_row_t r;
		r = '0;
		r.pixel = pix;
		return r;
	endfunction

	function automatic script_row_t checked_row(input logic [PIX_W-1:0] pix,
			input logic [PIX_W-1:0] w_pix, input logic w_in, input logic [OFF_W-1:0] w_soff,
			input logic [OFF_W-1:0] w_doff, input logic w_eof);
		script_row_t r;
		r = '0;
		r.pixel        = pix;
		r.typed        = 1'b1;
		r.want.pixel   = w_pix;
		r.want.in_src  = w_in;
		r.want.src_off = w_soff;
		r.want.dst_off = w_doff;
		r.want.eof     = w_eof;
		return r;
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_SRC_WIDTH:  frame_src_w = data[DIM_REG_W-1:0];
			REG_SRC_HEIGHT: frame_src_h = data[DIM_REG_W-1:0];
			REG_DST_WIDTH:  frame_dst_w = data[DIM_REG_W-1:0];
			REG_DST_HEIGHT: frame_dst_h = data[DIM_REG_W-1:0];
			REG_SRC_PB:     src_bpp     = data[PB_W-1:0];
			REG_DST_PB:     dst_bpp     = data[PB_W-1:0];
			REG_SRC_LB:     src_stride  = data[LB_W-1:0];
			default:        dst_stride  = data[LB_W-1:0];
		endcase
	endtask

	task automatic send_beat(input logic [PIX_W-1:0] pix, input logic typed,
			input pix_result_t typed_want);
		int          gap;
		pix_result_t predicted;
		gap = idle_len(tx_burst);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		src_pixel = pix;
		do @(posedge clk); while (in_stall);
		predicted = predict_pixel(pix);
		expected_pixels.push_back(typed ? typed_want : predicted);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (expected_pixels.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// The receiver stalls at random and, once the stream is well under way, holds off long
	// enough for the pipeline to fill and push back on the sender.
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && hold_go) begin
				hold_done  = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !out_stall) begin
				stall_left = idle_len(rx_burst);
			end
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen.pixel   = dst_pixel;
			seen.in_src  = inside_res;
			seen.src_off = src_offset;
			seen.dst_off = dst_offset;
			seen.eof     = end_of_frame;
			if (expected_pixels.size() == 0) begin
				$error("output beat with no expected pixel pending");
				failed = 1'b1;
			end else begin
				want = expected_pixels.pop_front();
				if (seen.pixel !== want.pixel) begin
					$error("dst_pixel: expected %h, got %h", want.pixel, seen.pixel);
					failed = 1'b1;
				end
				if (seen.in_src !== want.in_src) begin
					$error("inside_res: expected %b, got %b", want.in_src, seen.in_src);
					failed = 1'b1;
				end
				if (seen.src_off !== want.src_off) begin
					$error("src_offset: expected %0d, got %0d", want.src_off, seen.src_off);
					failed = 1'b1;
				end
				if (seen.dst_off !== want.dst_off) begin
					$error("dst_offset: expected %0d, got %0d", want.dst_off, seen.dst_off);
					failed = 1'b1;
				end
				if (seen.eof !== want.eof) begin
					$error("end_of_frame: expected %b, got %b", want.eof, seen.eof);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		script_row_t           row;
		bit                    dirty;
		int                    n;
		int                    r;
		bit                    first_phase;
		logic [CFG_DATA_W-1:0] v;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		src_pixel    = '0;
		beats_sent   = 0;
		quiet_cycles = 0;
		failed       = 1'b0;
		tx_burst     = 1'b0;
		rx_burst     = 1'b0;
		hold_done    = 1'b0;
		hold_go      = 1'b0;
		frame_src_w  = 15'd1;
		frame_src_h  = 15'd1;
		frame_dst_w  = 15'd1;
		frame_dst_h  = 15'd1;
		src_bpp      = 4'd3;
		dst_bpp      = 4'd3;
		src_stride   = 18'd3;
		dst_stride   = 18'd3;
		walk_x       = 0;
		walk_y       = 0;
		dirty        = 1'b0;
		first_phase  = 1'b1;

		// Reset state: one pixel frames, three byte pixels.
		script.push_back(checked_row(64'h0807060504030201, 64'h030201, 1'b1, 31'd0, 31'd0, 1'b1));
		script.push_back(checked_row('1, 64'hFFFFFF, 1'b1, 31'd0, 31'd0, 1'b1));
		script.push_back(checked_row('0, '0, 1'b1, 31'd0, 31'd0, 1'b1));
		// Narrowing with alpha, then widening with alpha fill.
		script.push_back(cfg_row(REG_SRC_PB, 18'd8));
		script.push_back(cfg_row(REG_DST_PB, 18'd4));
		script.push_back(checked_row(64'h8877665544332211, 64'h77553311, 1'b1, 31'd0, 31'd0,
			1'b1));
		script.push_back(cfg_row(REG_SRC_PB, 18'd3));
		script.push_back(cfg_row(REG_DST_PB, 18'd8));
		script.push_back(checked_row(64'h8877665544332211, 64'h003300220011FFFF, 1'b1, 31'd0,
			31'd0, 1'b1));
		// Unsupported pixel sizes give zero pixels.
		script.push_back(cfg_row(REG_SRC_PB, 18'd5));
		script.push_back(checked_row('1, '0, 1'b1, 31'd0, 31'd0, 1'b1));
		script.push_back(cfg_row(REG_SRC_PB, 18'd6));
		script.push_back(cfg_row(REG_DST_PB, 18'd7));
		script.push_back(checked_row('1, '0, 1'b1, 31'd0, 31'd0, 1'b1));
		script.push_back(cfg_row(REG_DST_PB, 18'd6));
		script.push_back(cfg_row(REG_SRC_LB, 18'd100));
		script.push_back(checked_row(64'h8877665544332211, 64'h665544332211, 1'b1, 31'd0,
			31'd0, 1'b1));
		// A four pixel row over a one pixel source: the centering shift of -3/2 truncates to -1.
		script.push_back(cfg_row(REG_DST_WIDTH, 18'd4));
		script.push_back(checked_row('1, '0, 1'b0, 31'd0, 31'd0, 1'b0));
		script.push_back(checked_row(64'h8877665544332211, 64'h665544332211, 1'b1, 31'd0,
			31'd6, 1'b0));
		script.push_back(checked_row('1, '0, 1'b0, 31'd0, 31'd12, 1'b0));
		script.push_back(checked_row('1, '0, 1'b0, 31'd0, 31'd18, 1'b1));
		// Zero and oversized dimensions, with bits above the register width set.
		script.push_back(cfg_row(REG_SRC_WIDTH, 18'd0));
		script.push_back(cfg_row(REG_DST_WIDTH, 18'd0));
		script.push_back(cfg_row(REG_DST_HEIGHT, 18'h3FFFF));
		script.push_back(cfg_row(REG_SRC_HEIGHT, 18'd20000));
		repeat (3) script.push_back(beat_row({$urandom, $urandom}));
		// The frame shrinks under the raster position.
		script.push_back(cfg_row(REG_DST_WIDTH, 18'd8));
		script.push_back(cfg_row(REG_SRC_WIDTH, 18'd5));
		repeat (5) script.push_back(beat_row({$urandom, $urandom}));
		script.push_back(cfg_row(REG_DST_WIDTH, 18'd3));
		script.push_back(cfg_row(REG_DST_HEIGHT, 18'd2));
		repeat (2) script.push_back(beat_row({$urandom, $urandom}));
		// Largest source and strides: the source offset wraps past 31 bits.
		script.push_back(cfg_row(REG_SRC_WIDTH, 18'd16384));
		script.push_back(cfg_row(REG_SRC_HEIGHT, 18'd16384));
		script.push_back(cfg_row(REG_DST_WIDTH, 18'd1));
		script.push_back(cfg_row(REG_SRC_LB, 18'h3FFFF));
		script.push_back(cfg_row(REG_DST_LB, 18'h3FFFF));
		script.push_back(cfg_row(REG_SRC_PB, 18'd15));
		script.push_back(cfg_row(REG_DST_PB, 18'd8));
		repeat (3) script.push_back(beat_row({$urandom, $urandom}));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (script[i]) begin
			row = script[i];
			if (row.is_write) begin
				if (dirty)
					settle();
				dirty = 1'b0;
				write_reg(row.idx, row.data);
			end else begin
				send_beat(row.pixel, row.typed, row.want);
				dirty = 1'b1;
			end
		end

		while (beats_sent < ITEM_TARGET) begin
			settle();
			tx_burst = $urandom_range(0, 4) == 0;
			rx_burst = $urandom_range(0, 4) == 0;
			for (int i = 0; i < 8; i++) begin
				if (first_phase || $urandom_range(0, 99) < 55) begin
					r = $urandom_range(0, 99);
					case (reg_idx_t'(i))
						REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH, REG_DST_HEIGHT: begin
							if (r < 70)
								v = CFG_DATA_W'($urandom_range(1, 12));
							else if (r < 80)
								v = CFG_DATA_W'($urandom_range(13, 40));
							else if (r < 88)
								v = CFG_DATA_W'($urandom_range(16383, 16384));
							else if (r < 94)
								v = '0;
							else
								v = CFG_DATA_W'($urandom_range(0, 18'h3FFFF));
						end
						REG_SRC_PB, REG_DST_PB: begin
							if (r < 85) begin
								case ($urandom_range(0, 3))
									0: v = 18'd3;
									1: v = 18'd4;
									2: v = 18'd6;
									default: v = 18'd8;
								endcase
							end else begin
								v = CFG_DATA_W'($urandom_range(0, 18'h3FFFF));
							end
						end
						default: begin
							if (r < 60)
								v = CFG_DATA_W'($urandom_range(3, 200));
							else if (r < 80)
								v = CFG_DATA_W'($urandom_range(0, 18'h3FFFF));
							else if (r < 90)
								v = 18'h3FFFF;
							else
								v = '0;
						end
					endcase
					write_reg(reg_idx_t'(i), v);
				end
			end
			first_phase = 1'b0;
			n = $urandom_range(8, 48);
			// One long burst goes out while the receiver holds off.
			if (!hold_done && beats_sent >= HOLD_AT_BEAT) begin
				n        = 48;
				tx_burst = 1'b1;
				hold_go  = 1'b1;
			end
			repeat (n) begin
				case ($urandom_range(0, 15))
					0: send_beat('1, 1'b0, '0);
					1: send_beat('0, 1'b0, '0);
					default: send_beat({$urandom, $urandom}, 1'b0, '0);
				endcase
			end
		end

		settle();
		if (!failed)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
